[hw/rtl/drld_pkg.sv]
// Shared types and constants for the NTFS data-run list decoder.
// No dependencies; used by every module in hw/rtl.
`timescale 1ns / 1ps

package drld_pkg;

   localparam int MAX_FIELD_BYTES = 8;

   localparam logic [7:0] NIBBLE_MASK = 8'h0F;
   localparam logic [7:0] SIGN_MASK   = 8'h80;
   localparam logic [7:0] BYTE_MASK   = 8'hFF;

   typedef enum logic [1:0] {
      PH_HEADER = 2'd0,
      PH_LENGTH = 2'd1,
      PH_OFFSET = 2'd2,
      PH_CLOSED = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      ST_RUN        = 2'd0,
      ST_TERMINATOR = 2'd1,
      ST_TRUNCATED  = 2'd2,
      ST_MALFORMED  = 2'd3
   } status_type;

   typedef struct packed {
      logic       valid;
      logic [7:0] list_byte;
      logic       list_start;
      logic       list_end;
   } beat_type;

   typedef struct packed {
      status_type  status;
      logic [63:0] run_clusters;
      logic [63:0] start_cluster;
      logic        sparse;
      logic        last;
   } result_type;

endpackage

[hw/rtl/data_run_list_decoder_top.sv]
// Top level of the NTFS data-run list decoder: input register plus decode core.
// Depends on drld_pkg, drld_in_reg and drld_core.
//
//   channel | dir | beat contents (lowest bit first)
//   req_    | in  | tdata: list_byte[7:0]; tuser: list_start; tlast: list_end
//   rsp_    | out | tdata: run_clusters[63:0], start_cluster[127:64];
//           |     | tuser: status[1:0], sparse[2]; tlast: last
//
// One byte beat is taken per cycle while rsp_ does not stall; a result passes the byte
// register and then the result register, which holds it until rsp_tready takes it.
// The single decode stage between the input and result registers sets the clock
// period: its longest path is the 64-bit add on the last offset byte of a run.
// Synchronous active-high reset empties both registers and returns to header.
// A stalled rsp_ stage holds the byte register and in turn req_tready.
`timescale 1ns / 1ps

module data_run_list_decoder_top #(
   parameter int MAX_FIELD_BYTES = drld_pkg::MAX_FIELD_BYTES
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // [7:0] list_byte
   input  logic         req_tuser,   // [0] list_start
   input  logic         req_tlast,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [127:0] rsp_tdata,   // [63:0] run_clusters, [127:64] start_cluster
   output logic [2:0]   rsp_tuser,   // [1:0] status, [2] sparse
   output logic         rsp_tlast
);

   drld_pkg::beat_type   beat;
   drld_pkg::result_type rsp;
   logic                 take;

   drld_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .take       (take),
      .beat       (beat)
   );

   drld_core #(
      .MAX_FIELD_BYTES (MAX_FIELD_BYTES)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .beat      (beat),
      .take      (take),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp       (rsp)
   );

   assign rsp_tdata = {rsp.start_cluster, rsp.run_clusters};
   assign rsp_tuser = {rsp.sparse, rsp.status};
   assign rsp_tlast = rsp.last;

endmodule

[hw/rtl/drld_in_reg.sv]
// Input register for the run-list decoder: holds one accepted byte beat.
// Depends on drld_pkg.
`timescale 1ns / 1ps

module drld_in_reg (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [7:0]         req_tdata,
   input  logic               req_tuser,
   input  logic               req_tlast,
   input  logic               take,
   output drld_pkg::beat_type beat
);

   logic       valid_ff;
   logic       valid_in;
   logic [7:0] byte_ff;
   logic       start_ff;
   logic       end_ff;
   logic       accept;

   assign req_tready = !valid_ff || take;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      if (accept) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         byte_ff  <= req_tdata;
         start_ff <= req_tuser;
         end_ff   <= req_tlast;
      end
   end

   assign beat.valid      = valid_ff;
   assign beat.list_byte  = byte_ff;
   assign beat.list_start = start_ff;
   assign beat.list_end   = end_ff;

endmodule

[hw/rtl/drld_core.sv]
// Run-list decode state, per-byte update logic and the result register.
// Depends on drld_pkg.
`timescale 1ns / 1ps

module drld_core #(
   parameter int MAX_FIELD_BYTES = drld_pkg::MAX_FIELD_BYTES
) (
   input  logic                 clock,
   input  logic                 reset,
   input  drld_pkg::beat_type   beat,
   output logic                 take,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output drld_pkg::result_type rsp
);

   drld_pkg::phase_type  phase_ff, phase_in;
   logic [3:0]           lleft_ff, lleft_in;
   logic [3:0]           oleft_ff, oleft_in;
   logic [2:0]           pos_ff, pos_in;
   logic [63:0]          cnt_ff, cnt_in;
   logic [63:0]          off_ff, off_in;
   logic [63:0]          run_ff, run_in;
   logic                 present_ff, present_in;
   logic                 out_valid_ff;
   drld_pkg::result_type rsp_ff;

   drld_pkg::result_type res;
   logic                 emit;
   logic [3:0]           lsz;
   logic [3:0]           osz;
   logic [63:0]          byte_shifted;
   logic [63:0]          sign_fill;
   logic [63:0]          off_full;
   logic [63:0]          run_sum;
   logic [7:0]           b;

   assign take = beat.valid && (!out_valid_ff || rsp_ready);
   assign b    = beat.list_byte;
   assign lsz  = 4'(b & drld_pkg::NIBBLE_MASK);
   assign osz  = 4'((b >> 4) & drld_pkg::NIBBLE_MASK);

   always_comb begin
      phase_in   = phase_ff;
      lleft_in   = lleft_ff;
      oleft_in   = oleft_ff;
      pos_in     = pos_ff;
      cnt_in     = cnt_ff;
      off_in     = off_ff;
      run_in     = run_ff;
      present_in = present_ff;
      emit       = 1'b0;
      res        = '0;

      // restart drops any partial run and the running cluster
      if (beat.list_start) begin
         phase_in   = drld_pkg::PH_HEADER;
         lleft_in   = 4'd0;
         oleft_in   = 4'd0;
         pos_in     = 3'd0;
         cnt_in     = 64'd0;
         off_in     = 64'd0;
         run_in     = 64'd0;
         present_in = 1'b0;
      end

      byte_shifted = {56'd0, b} << {pos_in, 3'b000};
      sign_fill    = {64{1'b1}} << {({1'b0, pos_in} + 4'd1), 3'b000};
      off_full     = off_in | byte_shifted;
      if (((b & drld_pkg::SIGN_MASK) != 8'd0) && (pos_in != 3'd7)) begin
         off_full = off_full | sign_fill;
      end
      run_sum = run_in + off_full;

      unique case (phase_in)
         drld_pkg::PH_HEADER: begin
            if (b == 8'd0) begin
               emit       = 1'b1;
               res.status = drld_pkg::ST_TERMINATOR;
               res.last   = 1'b1;
               phase_in   = drld_pkg::PH_CLOSED;
            end else if ((32'(lsz) > MAX_FIELD_BYTES) ||
                         (32'(osz) > MAX_FIELD_BYTES)) begin
               emit       = 1'b1;
               res.status = drld_pkg::ST_MALFORMED;
               res.last   = 1'b1;
               phase_in   = drld_pkg::PH_CLOSED;
            end else if (beat.list_end) begin
               emit       = 1'b1;
               res.status = drld_pkg::ST_TRUNCATED;
               res.last   = 1'b1;
               phase_in   = drld_pkg::PH_CLOSED;
            end else begin
               lleft_in   = lsz;
               oleft_in   = osz;
               pos_in     = 3'd0;
               cnt_in     = 64'd0;
               off_in     = 64'd0;
               present_in = (osz != 4'd0);
               phase_in   = (lsz != 4'd0) ? drld_pkg::PH_LENGTH : drld_pkg::PH_OFFSET;
            end
         end
         drld_pkg::PH_LENGTH: begin
            cnt_in   = cnt_in | byte_shifted;
            lleft_in = lleft_in - 4'd1;
            pos_in   = pos_in + 3'd1;
            if (lleft_in == 4'd0 && oleft_in == 4'd0) begin
               // run without an offset field: sparse
               emit              = 1'b1;
               res.status        = drld_pkg::ST_RUN;
               res.run_clusters  = cnt_in;
               res.start_cluster = {64{1'b1}};
               res.sparse        = 1'b1;
               res.last          = beat.list_end;
               phase_in   = beat.list_end ? drld_pkg::PH_CLOSED : drld_pkg::PH_HEADER;
               pos_in     = 3'd0;
               cnt_in     = 64'd0;
               off_in     = 64'd0;
               present_in = 1'b0;
            end else begin
               if (lleft_in == 4'd0) begin
                  pos_in   = 3'd0;
                  phase_in = drld_pkg::PH_OFFSET;
               end
               if (beat.list_end) begin
                  emit       = 1'b1;
                  res.status = drld_pkg::ST_TRUNCATED;
                  res.last   = 1'b1;
                  phase_in   = drld_pkg::PH_CLOSED;
                  lleft_in   = 4'd0;
                  oleft_in   = 4'd0;
                  pos_in     = 3'd0;
                  cnt_in     = 64'd0;
                  present_in = 1'b0;
               end
            end
         end
         drld_pkg::PH_OFFSET: begin
            oleft_in = oleft_in - 4'd1;
            if (oleft_in == 4'd0) begin
               emit             = 1'b1;
               res.status       = drld_pkg::ST_RUN;
               res.run_clusters = cnt_in;
               res.last         = beat.list_end;
               if (present_in) begin
                  run_in            = run_sum;
                  res.start_cluster = run_sum;
               end else begin
                  res.start_cluster = {64{1'b1}};
                  res.sparse        = 1'b1;
               end
               phase_in   = beat.list_end ? drld_pkg::PH_CLOSED : drld_pkg::PH_HEADER;
               lleft_in   = 4'd0;
               pos_in     = 3'd0;
               cnt_in     = 64'd0;
               off_in     = 64'd0;
               present_in = 1'b0;
            end else begin
               off_in = off_in | byte_shifted;
               pos_in = pos_in + 3'd1;
               if (beat.list_end) begin
                  emit       = 1'b1;
                  res.status = drld_pkg::ST_TRUNCATED;
                  res.last   = 1'b1;
                  phase_in   = drld_pkg::PH_CLOSED;
                  lleft_in   = 4'd0;
                  oleft_in   = 4'd0;
                  pos_in     = 3'd0;
                  cnt_in     = 64'd0;
                  off_in     = 64'd0;
                  present_in = 1'b0;
               end
            end
         end
         drld_pkg::PH_CLOSED: begin
            emit = 1'b0;
         end
         default: begin
            emit = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= drld_pkg::PH_HEADER;
         lleft_ff   <= 4'd0;
         oleft_ff   <= 4'd0;
         pos_ff     <= 3'd0;
         cnt_ff     <= 64'd0;
         off_ff     <= 64'd0;
         run_ff     <= 64'd0;
         present_ff <= 1'b0;
      end else if (take) begin
         phase_ff   <= phase_in;
         lleft_ff   <= lleft_in;
         oleft_ff   <= oleft_in;
         pos_ff     <= pos_in;
         cnt_ff     <= cnt_in;
         off_ff     <= off_in;
         run_ff     <= run_in;
         present_ff <= present_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (take) begin
         out_valid_ff <= emit;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take && emit) begin
         rsp_ff <= res;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp       = rsp_ff;

endmodule

[sim/drld_checker.sv]
// Scoreboard for the data-run list decoder: predicts run records from accepted byte beats.
// Depends on drld_pkg; sits beside u_dut in tb and reports its failure count upward.
`timescale 1ns / 1ps

module drld_checker (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [7:0]   req_tdata,   // [7:0] list_byte
   input  logic         req_tuser,   // [0] list_start
   input  logic         req_tlast,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [127:0] rsp_tdata,   // [63:0] run_clusters, [127:64] start_cluster
   input  logic [2:0]   rsp_tuser,   // [1:0] status, [2] sparse
   input  logic         rsp_tlast,
   input  logic         drain_done,
   output int           fail_count,
   output int           pending,
   output int           runs_seen,
   output int           sparse_seen,
   output int           terminators_seen,
   output int           truncations_seen,
   output int           malformed_seen
);

   drld_pkg::phase_type  walk_phase;
   logic [3:0]           len_left;
   logic [3:0]           off_left;
   logic [2:0]           byte_idx;
   logic [63:0]          cluster_count;
   logic [63:0]          delta;
   logic [63:0]          lcn;
   logic                 has_delta;
   logic                 tail_checked;
   drld_pkg::result_type run_records_due[$];
   drld_pkg::result_type due;

   task automatic note_failure(input string msg);
      if (fail_count < 40) begin
         $display("ERROR %0t: %s", $time, msg);
      end
      fail_count++;
   endtask

   task automatic queue_due(input drld_pkg::result_type rec);
      run_records_due = {run_records_due, rec};
   endtask

   task automatic clear_run();
      len_left      = '0;
      off_left      = '0;
      byte_idx      = '0;
      cluster_count = '0;
      delta         = '0;
      has_delta     = 1'b0;
   endtask

   task automatic close_list(input drld_pkg::status_type s);
      drld_pkg::result_type rec;
      rec.status        = s;
      rec.run_clusters  = '0;
      rec.start_cluster = '0;
      rec.sparse        = 1'b0;
      rec.last          = 1'b1;
      queue_due(rec);
      clear_run();
      walk_phase = drld_pkg::PH_CLOSED;
   endtask

   task automatic finish_run(input logic closing);
      drld_pkg::result_type rec;
      rec.status       = drld_pkg::ST_RUN;
      rec.run_clusters = cluster_count;
      rec.last         = closing;
      if (has_delta) begin
         lcn               = lcn + delta;
         rec.start_cluster = lcn;
         rec.sparse        = 1'b0;
      end else begin
         rec.start_cluster = '1;
         rec.sparse        = 1'b1;
      end
      queue_due(rec);
      clear_run();
      walk_phase = closing ? drld_pkg::PH_CLOSED : drld_pkg::PH_HEADER;
   endtask

   task automatic decode_byte(input logic [7:0] b, input logic first, input logic final_byte);
      logic [3:0] lsz;
      logic [3:0] osz;
      logic [2:0] p;
      lsz = b[3:0];
      osz = b[7:4];
      if (first) begin
         walk_phase = drld_pkg::PH_HEADER;
         clear_run();
         lcn = '0;
      end
      case (walk_phase)
         drld_pkg::PH_CLOSED: begin
         end
         drld_pkg::PH_HEADER: begin
            if (b == 8'h00) begin
               close_list(drld_pkg::ST_TERMINATOR);
            end else if (lsz > drld_pkg::MAX_FIELD_BYTES ||
                         osz > drld_pkg::MAX_FIELD_BYTES) begin
               close_list(drld_pkg::ST_MALFORMED);
            end else if (final_byte) begin
               close_list(drld_pkg::ST_TRUNCATED);
            end else begin
               clear_run();
               len_left   = lsz;
               off_left   = osz;
               has_delta  = (osz != 0);
               walk_phase = (lsz != 0) ? drld_pkg::PH_LENGTH : drld_pkg::PH_OFFSET;
            end
         end
         drld_pkg::PH_LENGTH: begin
            cluster_count = cluster_count | ({56'd0, b} << (8 * byte_idx));
            byte_idx      = byte_idx + 3'd1;
            len_left      = len_left - 4'd1;
            if (len_left == 0 && off_left == 0) begin
               finish_run(final_byte);
            end else begin
               if (len_left == 0) begin
                  byte_idx   = '0;
                  walk_phase = drld_pkg::PH_OFFSET;
               end
               if (final_byte) begin
                  close_list(drld_pkg::ST_TRUNCATED);
               end
            end
         end
         default: begin
            p        = byte_idx;
            delta    = delta | ({56'd0, b} << (8 * p));
            off_left = off_left - 4'd1;
            if (off_left == 0) begin
               if (b[7] && p < 3'd7) begin
                  delta = delta | ({64{1'b1}} << (8 * (p + 1)));
               end
               finish_run(final_byte);
            end else begin
               byte_idx = p + 3'd1;
               if (final_byte) begin
                  close_list(drld_pkg::ST_TRUNCATED);
               end
            end
         end
      endcase
   endtask

   always @(posedge clock) begin
      if (reset) begin
         walk_phase = drld_pkg::PH_HEADER;
         clear_run();
         lcn = '0;
         run_records_due.delete();
         tail_checked     = 1'b0;
         pending          = 0;
         fail_count       = 0;
         runs_seen        = 0;
         sparse_seen      = 0;
         terminators_seen = 0;
         truncations_seen = 0;
         malformed_seen   = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            decode_byte(req_tdata, req_tuser, req_tlast);
         end
         if (rsp_tvalid && rsp_tready) begin
            case (drld_pkg::status_type'(rsp_tuser[1:0]))
               drld_pkg::ST_RUN: begin
                  runs_seen++;
                  if (rsp_tuser[2]) sparse_seen++;
               end
               drld_pkg::ST_TERMINATOR: terminators_seen++;
               drld_pkg::ST_TRUNCATED:  truncations_seen++;
               default:                 malformed_seen++;
            endcase
            if (run_records_due.size() == 0) begin
               note_failure($sformatf("result beat with nothing due, status %0d",
                                      rsp_tuser[1:0]));
            end else begin
               due = run_records_due.pop_front();
               if (rsp_tuser[1:0] !== due.status)
                  note_failure($sformatf("status got %0d want %0d",
                                         rsp_tuser[1:0], due.status));
               if (rsp_tdata[63:0] !== due.run_clusters)
                  note_failure($sformatf("run_clusters got %h want %h",
                                         rsp_tdata[63:0], due.run_clusters));
               if (rsp_tdata[127:64] !== due.start_cluster)
                  note_failure($sformatf("start_cluster got %h want %h",
                                         rsp_tdata[127:64], due.start_cluster));
               if (rsp_tuser[2] !== due.sparse)
                  note_failure($sformatf("sparse got %b want %b", rsp_tuser[2], due.sparse));
               if (rsp_tlast !== due.last)
                  note_failure($sformatf("last got %b want %b", rsp_tlast, due.last));
            end
         end
         if (drain_done && !tail_checked) begin
            tail_checked = 1'b1;
            if (run_records_due.size() != 0)
               note_failure($sformatf("%0d results never arrived", run_records_due.size()));
         end
         pending = run_records_due.size();
      end
   end

endmodule

[sim/tb.sv]
// Testbench top for data_run_list_decoder_top: drives run-list byte beats with bursts
// and gaps, stalls the result side, and gives the verdict. Depends on drld_pkg and drld_checker.
`timescale 1ns / 1ps

module tb;

   typedef enum {RX_STEADY, RX_COIN, RX_MOSTLY, RX_STARVED} rx_mode_type;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [7:0]   req_tdata;
   logic         req_tuser;
   logic         req_tlast;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [127:0] rsp_tdata;
   logic [2:0]   rsp_tuser;
   logic         rsp_tlast;
   logic         drain_done;

   int fail_count;
   int pending;
   int runs_seen;
   int sparse_seen;
   int terminators_seen;
   int truncations_seen;
   int malformed_seen;

   int items_sent;
   int beats_total;
   int burst_left;
   int wait_cycles;

   data_run_list_decoder_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   drld_checker u_chk (
      .clock            (clock),
      .reset            (reset),
      .req_tvalid       (req_tvalid),
      .req_tready       (req_tready),
      .req_tdata        (req_tdata),
      .req_tuser        (req_tuser),
      .req_tlast        (req_tlast),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_tready       (rsp_tready),
      .rsp_tdata        (rsp_tdata),
      .rsp_tuser        (rsp_tuser),
      .rsp_tlast        (rsp_tlast),
      .drain_done       (drain_done),
      .fail_count       (fail_count),
      .pending          (pending),
      .runs_seen        (runs_seen),
      .sparse_seen      (sparse_seen),
      .terminators_seen (terminators_seen),
      .truncations_seen (truncations_seen),
      .malformed_seen   (malformed_seen)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // enter and leave at a falling edge; valid stays high across back-to-back beats
   task automatic send_beat(input logic [7:0] b, input logic first, input logic final_byte,
                            input bit counted);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 30);
         gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_tvalid = 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_tvalid = 1'b1;
      req_tdata  = b;
      req_tuser  = first;
      req_tlast  = final_byte;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      beats_total++;
      if (counted) items_sent++;
      @(negedge clock);
   endtask

   task automatic pick_sizes(output int lsz, output int osz);
      lsz = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 8) : $urandom_range(0, 3);
      osz = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 8) : $urandom_range(0, 3);
      if (lsz == 0 && osz == 0) lsz = 1;
   endtask

   // header plus field bytes up to and including index stop
   task automatic send_run(input int lsz, input int osz, input bit first, input int stop,
                           input bit final_byte);
      logic [3:0] ln;
      logic [3:0] on;
      ln = 4'(lsz);
      on = 4'(osz);
      for (int i = 0; i <= stop; i++) begin
         send_beat((i == 0) ? {on, ln} : 8'($urandom_range(0, 255)),
                   first && (i == 0), final_byte && (i == stop), 1'b1);
      end
   endtask

   task automatic trail_closed();
      repeat ($urandom_range(0, 2)) begin
         send_beat(8'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1)), 1'b0);
      end
   endtask

   task automatic random_list();
      int  runs;
      int  ending;
      int  lsz;
      int  osz;
      bit  first;
      logic [3:0] big;
      logic [3:0] any;
      if ($urandom_range(0, 99) < 8) begin
         repeat ($urandom_range(1, 12)) begin
            send_beat(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0,
                      $urandom_range(0, 9) == 0, 1'b1);
         end
      end else begin
         first = 1'b1;
         runs  = $urandom_range(0, 5);
         repeat (runs) begin
            pick_sizes(lsz, osz);
            send_run(lsz, osz, first, lsz + osz, 1'b0);
            first = 1'b0;
         end
         ending = $urandom_range(0, 99);
         if (ending < 55) begin
            send_beat(8'h00, first, 1'($urandom_range(0, 1)), 1'b1);
            trail_closed();
         end else if (ending < 70) begin
            pick_sizes(lsz, osz);
            send_run(lsz, osz, first, lsz + osz, 1'b1);
            trail_closed();
         end else if (ending < 82) begin
            pick_sizes(lsz, osz);
            send_run(lsz, osz, first, $urandom_range(0, lsz + osz - 1), 1'b1);
            trail_closed();
         end else if (ending < 90) begin
            big = 4'($urandom_range(9, 15));
            any = 4'($urandom_range(0, 15));
            send_beat($urandom_range(0, 1) ? {big, any} : {any, big}, first,
                      1'($urandom_range(0, 1)), 1'b1);
            trail_closed();
         end else begin
            // abandon mid-run; the next list restarts it
            pick_sizes(lsz, osz);
            send_run(lsz, osz, first, $urandom_range(0, lsz + osz - 1), 1'b0);
         end
      end
   endtask

   // result side: changing stall pattern, plus one long hold-off
   initial begin
      rx_mode_type rx_mode;
      int          rx_left;
      bit          held;
      rx_mode    = RX_STEADY;
      rx_left    = 0;
      held       = 1'b0;
      rsp_tready = 1'b0;
      @(negedge reset);
      forever begin
         @(negedge clock);
         if (!held && beats_total >= 700) begin
            held       = 1'b1;
            rsp_tready = 1'b0;
            repeat (400) @(negedge clock);
         end
         if (rx_left == 0) begin
            rx_left = $urandom_range(20, 200);
            rx_mode = rx_mode_type'($urandom_range(0, 3));
         end
         rx_left--;
         case (rx_mode)
            RX_STEADY:  rsp_tready = 1'b1;
            RX_COIN:    rsp_tready = 1'($urandom_range(0, 1));
            RX_MOSTLY:  rsp_tready = $urandom_range(0, 9) != 0;
            default:    rsp_tready = $urandom_range(0, 3) == 0;
         endcase
      end
   end

   initial begin
      #4000000;
      $display("timeout: run did not drain");
      $display("== FAIL ==");
      $finish;
   end

   initial begin
      clock       = 1'b0;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = 1'b0;
      req_tlast   = 1'b0;
      drain_done  = 1'b0;
      items_sent  = 0;
      beats_total = 0;
      burst_left  = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: extremes, sparse, zero length, terminator, ignored byte, malformed,
      // truncation at header / mid-length / before offset, end on complete run, restart
      send_beat(8'h11, 1'b1, 1'b0, 1'b1);
      send_beat(8'hFF, 1'b0, 1'b0, 1'b1);
      send_beat(8'h80, 1'b0, 1'b0, 1'b1);
      send_beat(8'h01, 1'b0, 1'b0, 1'b1);
      send_beat(8'h00, 1'b0, 1'b0, 1'b1);
      send_beat(8'h10, 1'b0, 1'b0, 1'b1);
      send_beat(8'h7F, 1'b0, 1'b0, 1'b1);
      send_beat(8'h00, 1'b0, 1'b0, 1'b1);
      send_beat(8'h5A, 1'b0, 1'b0, 1'b0);
      send_beat(8'h09, 1'b1, 1'b0, 1'b1);
      send_beat(8'h90, 1'b1, 1'b0, 1'b1);
      send_beat(8'h21, 1'b1, 1'b1, 1'b1);
      send_beat(8'h12, 1'b1, 1'b0, 1'b1);
      send_beat(8'h01, 1'b0, 1'b0, 1'b1);
      send_beat(8'h02, 1'b0, 1'b1, 1'b1);
      send_beat(8'h21, 1'b1, 1'b0, 1'b1);
      send_beat(8'h03, 1'b0, 1'b0, 1'b1);
      send_beat(8'hFF, 1'b0, 1'b0, 1'b1);
      send_beat(8'h7F, 1'b0, 1'b1, 1'b1);
      send_beat(8'h11, 1'b1, 1'b0, 1'b1);
      send_beat(8'h04, 1'b0, 1'b0, 1'b1);
      send_beat(8'h01, 1'b1, 1'b0, 1'b1);
      send_beat(8'h07, 1'b0, 1'b1, 1'b1);
      send_beat(8'h02, 1'b1, 1'b0, 1'b1);
      send_beat(8'h01, 1'b0, 1'b1, 1'b1);

      while (beats_total < 1950) random_list();
      req_tvalid = 1'b0;

      wait_cycles = 0;
      while (pending != 0 && wait_cycles < 20000) begin
         @(negedge clock);
         wait_cycles++;
      end
      repeat (8) @(negedge clock);
      drain_done = 1'b1;
      @(posedge clock);
      @(negedge clock);

      $display("Sent %0d byte beats (%0d decoded); checked %0d run records, %0d sparse,",
               beats_total, items_sent, runs_seen, sparse_seen);
      $display("plus %0d terminators, %0d truncated lists and %0d malformed headers.",
               terminators_seen, truncations_seen, malformed_seen);
      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

[filelist.f]
hw/rtl/drld_pkg.sv
hw/rtl/drld_in_reg.sv
hw/rtl/drld_core.sv
hw/rtl/data_run_list_decoder_top.sv
sim/drld_checker.sv
sim/tb.sv
